>>> design/rdc_pkg.sv
// Shared constants, types and helper functions of the radix digit converter.
`default_nettype none

package rdc_pkg;

  // Width of the input value and the sizes that follow from it.
  localparam int VALUE_BITS = 31;
  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = 4;
  localparam int RECIP_W    = VALUE_BITS + 1;
  localparam int PROD_W     = VALUE_BITS + RECIP_W;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int IDX_W      = $clog2(VALUE_BITS);

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

  // Two to the power RECIP_W, the numerator of every reciprocal.
  localparam logic [RECIP_W:0] RECIP_NUM = {1'b1, {RECIP_W{1'b0}}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // take a new value, empty the digit stack
    logic mul;    // multiply the working value by the reciprocal
    logic step;   // correct the quotient, push one digit
    logic pop;    // move the top digit into the output register
  } rdc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic quot_zero;  // the corrected quotient of this step is zero
    logic last_one;   // exactly one digit is left on the stack
    logic out_free;   // the output register can take a digit this cycle
  } rdc_sts_t;

  // Register values below two act as two, values above sixteen as sixteen.
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  // floor(2^RECIP_W / d) for each legal radix. The product with a value
  // below 2^VALUE_BITS, shifted down, is the true quotient or one less.
  function automatic logic [RECIP_W-1:0] radix_recip(input logic [RADIX_W-1:0] d);
    logic [RECIP_W:0] t;
    case (d)
      RADIX_W'(3):  t = RECIP_NUM / 3;
      RADIX_W'(4):  t = RECIP_NUM / 4;
      RADIX_W'(5):  t = RECIP_NUM / 5;
      RADIX_W'(6):  t = RECIP_NUM / 6;
      RADIX_W'(7):  t = RECIP_NUM / 7;
      RADIX_W'(8):  t = RECIP_NUM / 8;
      RADIX_W'(9):  t = RECIP_NUM / 9;
      RADIX_W'(10): t = RECIP_NUM / 10;
      RADIX_W'(11): t = RECIP_NUM / 11;
      RADIX_W'(12): t = RECIP_NUM / 12;
      RADIX_W'(13): t = RECIP_NUM / 13;
      RADIX_W'(14): t = RECIP_NUM / 14;
      RADIX_W'(15): t = RECIP_NUM / 15;
      RADIX_W'(16): t = RECIP_NUM / 16;
      default:      t = RECIP_NUM / 2;
    endcase
    return t[RECIP_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> design/rdc_channels.sv
// Valid/ready channel interfaces for the input value and the output digits.
`default_nettype none

interface rdc_value_if import rdc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rdc_digit_if import rdc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit;
  logic               last_digit;

  modport source (output valid, output digit, output last_digit, input ready);
  modport sink   (input valid, input digit, input last_digit, output ready);
endinterface

`default_nettype wire

>>> design/radix_digit_converter.sv
// Top level of the radix digit converter.
`default_nettype none

// The block converts a non-negative VALUE_BITS-wide integer into its digits
// in the radix held in the configuration register (reset value ten; values
// below two act as two and values above sixteen act as sixteen). Each input
// transaction yields one output transaction per digit, most significant
// digit first, with last_digit set on the least significant digit; zero
// gives the single digit 0, and there are never leading zeros. Digits come
// from repeated division: each division multiplies the working value by a
// constant reciprocal of the radix and registers the product, then corrects
// the quotient in the next cycle. Once the quotient reaches zero, the digits
// move off a stack into the output register whenever it is free (a value has
// at most 31 digits, at radix two). A single shared reciprocal multiplier
// does every division. A new value is accepted once the final digit has
// entered the output register, even if that digit is still waiting to be
// taken. Write the radix only while no conversion is in flight.
module radix_digit_converter import rdc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [RADIX_W-1:0] cfg_wdata,
  rdc_value_if.sink               value_ch,
  rdc_digit_if.source             digit_ch
);

  rdc_cmd_t cmd;
  rdc_sts_t sts;

  // The controller sequences load, divide and emit; it never touches data.
  rdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (value_ch.valid),
    .in_ready (value_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath owns the radix register, the divider, the digit stack and
  // the output register that drives the digit channel.
  rdc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_value  (value_ch.value),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (digit_ch.valid),
    .out_ready (digit_ch.ready),
    .out_digit (digit_ch.digit),
    .out_last  (digit_ch.last_digit)
  );

endmodule

`default_nettype wire

>>> design/rdc_ctrl.sv
// Controller state machine of the radix digit converter.
`default_nettype none

module rdc_ctrl import rdc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire rdc_sts_t  sts,
  output rdc_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_CORR = 4'b0100,
    S_EMIT = 4'b1000
  } rdc_state_t;

  rdc_state_t state;
  rdc_state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.load = in_valid && (state == S_IDLE);
    cmd.mul  = (state == S_MUL);
    cmd.step = (state == S_CORR);
    cmd.pop  = (state == S_EMIT) && sts.out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_CORR;
      end
      S_CORR: begin
        state_next = sts.quot_zero ? S_EMIT : S_MUL;
      end
      S_EMIT: begin
        if (sts.out_free && sts.last_one) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> design/rdc_datapath.sv
// Datapath: radix register, reciprocal divider, digit stack and output register.
`default_nettype none

module rdc_datapath import rdc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [RADIX_W-1:0]    cfg_wdata,
  input  wire logic [VALUE_BITS-1:0] in_value,
  input  wire rdc_cmd_t              cmd,
  output rdc_sts_t                   sts,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [DIGIT_W-1:0]         out_digit,
  output logic                       out_last
);

  logic [RADIX_W-1:0]    radix;
  logic [VALUE_BITS-1:0] work;
  logic [PROD_W-1:0]     prod;
  logic [CNT_W-1:0]      count;
  logic [DIGIT_W-1:0]    stack [VALUE_BITS];

  logic [RADIX_W-1:0]    eff_radix;
  logic [RECIP_W-1:0]    recip;
  logic [VALUE_BITS-1:0] q_est;
  logic [RADIX_W-1:0]    low_prod;
  logic [RADIX_W-1:0]    rem_raw;
  logic                  rem_over;
  logic [DIGIT_W-1:0]    digit_new;
  logic [VALUE_BITS-1:0] quot;
  logic [CNT_W-1:0]      count_dec;

  assign eff_radix = clamp_radix(radix);
  assign recip     = radix_recip(eff_radix);

  // The estimate is the true quotient or one below it, so the remainder
  // lies below twice the radix and its low bits are enough to find it.
  assign q_est     = prod[PROD_W-1 -: VALUE_BITS];
  assign low_prod  = RADIX_W'(q_est[RADIX_W-1:0] * eff_radix);
  assign rem_raw   = work[RADIX_W-1:0] - low_prod;
  assign rem_over  = (rem_raw >= eff_radix);
  assign digit_new = rem_over ? DIGIT_W'(rem_raw - eff_radix) : rem_raw[DIGIT_W-1:0];
  assign quot      = q_est + VALUE_BITS'(rem_over);
  assign count_dec = count - CNT_W'(1);

  always_comb begin
    sts.quot_zero = (quot == '0);
    sts.last_one  = (count == CNT_W'(1));
    sts.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix     <= RADIX_RESET;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        radix <= cfg_wdata;
      end
      if (cmd.load) begin
        count <= '0;
      end else if (cmd.step) begin
        count <= count + CNT_W'(1);
      end else if (cmd.pop) begin
        count <= count_dec;
      end
      if (cmd.pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work <= in_value;
    end else if (cmd.step) begin
      work <= quot;
    end
    if (cmd.mul) begin
      prod <= work * recip;
    end
    if (cmd.step) begin
      stack[count[IDX_W-1:0]] <= digit_new;
    end
    if (cmd.pop) begin
      out_digit <= stack[count_dec[IDX_W-1:0]];
      out_last  <= (count == CNT_W'(1));
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(VALUE_BITS))
    else $error("digit count exceeds the value width");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (count != '0))
    else $error("digit popped from an empty stack");

  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop && count == CNT_W'(1)) |=> (count == '0) && out_last)
    else $error("final digit did not empty the stack");

  a_digit_in_radix: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, out_digit} < eff_radix))
    else $error("digit not below the radix");

endmodule

`default_nettype wire

>>> tb/sv/radix_digit_converter_tb.sv
// Self-checking testbench for the radix digit converter: directed table, random values, predictor.
`default_nettype none

module radix_digit_converter_tb import rdc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Clocking and run control. The watchdog limit sits well above the long
  // receiver hold-off, which is the longest stretch with no transaction in a
  // correct run.
  localparam int CLK_HALF          = 10;
  localparam int RESET_CYCLES      = 5;
  localparam int SETTLE_CYCLES     = 4;
  localparam int DRAIN_CYCLES      = 20;
  localparam int LONG_STALL_CYCLES = 400;
  localparam int WATCHDOG_LIMIT    = 2000;
  localparam int PHASES            = 3;
  localparam int SEGMENTS          = 4;
  localparam int ITEMS_PER_SEGMENT = 37;
  localparam int UPPER_BITS        = VALUE_BITS - 1;

  // One digit transaction as the output channel carries it.
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last_digit;
  } digit_item_t;

  // One row of the directed table. When typed_count is nonzero, the expected
  // digits are typed in right-aligned, one hex nibble per digit, most
  // significant digit in the highest nibble; otherwise the predictor works
  // them out.
  typedef struct packed {
    logic                  set_radix;
    logic [RADIX_W-1:0]    radix;
    logic [VALUE_BITS-1:0] value;
    logic [5:0]            typed_count;
    logic [127:0]          typed_digits;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 23;

  // The first rows run at the reset radix of ten without any register write.
  // Then come the extremes of the value field at radix sixteen and two, the
  // longest digit run (radix two with the top bit set), register values below
  // two and above sixteen, and a few radices whose digits are not read off at
  // a glance and so go to the predictor.
  directed_row_t directed_table [DIRECTED_ROWS] = '{
    '{1'b0, RADIX_W'(0),  31'd0,          6'd1,  128'h0},
    '{1'b0, RADIX_W'(0),  31'd2147483647, 6'd10, 128'h2147483647},
    '{1'b0, RADIX_W'(0),  31'd9,          6'd1,  128'h9},
    '{1'b0, RADIX_W'(0),  31'd10,         6'd2,  128'h10},
    '{1'b0, RADIX_W'(0),  31'd1,          6'd1,  128'h1},
    '{1'b1, RADIX_W'(16), 31'h7FFFFFFF,   6'd8,  128'h7FFFFFFF},
    '{1'b0, RADIX_W'(0),  31'h12345678,   6'd8,  128'h12345678},
    '{1'b0, RADIX_W'(0),  31'd15,         6'd1,  128'hF},
    '{1'b0, RADIX_W'(0),  31'd16,         6'd2,  128'h10},
    '{1'b1, RADIX_W'(2),  31'h7FFFFFFF,   6'd31, 128'({31{4'h1}})},
    '{1'b0, RADIX_W'(0),  31'h40000000,   6'd31, (128'h1 << 120)},
    '{1'b0, RADIX_W'(0),  31'd1,          6'd1,  128'h1},
    '{1'b0, RADIX_W'(0),  31'd0,          6'd1,  128'h0},
    '{1'b1, RADIX_W'(0),  31'd5,          6'd3,  128'h101},
    '{1'b1, RADIX_W'(1),  31'd6,          6'd3,  128'h110},
    '{1'b1, RADIX_W'(17), 31'hABCDEF,     6'd6,  128'hABCDEF},
    '{1'b1, RADIX_W'(31), 31'h7FFFFFFF,   6'd8,  128'h7FFFFFFF},
    '{1'b1, RADIX_W'(8),  31'h7FFFFFFF,   6'd11, 128'h17777777777},
    '{1'b1, RADIX_W'(3),  31'h7FFFFFFF,   6'd0,  128'h0},
    '{1'b1, RADIX_W'(7),  31'd12345,      6'd0,  128'h0},
    '{1'b1, RADIX_W'(15), 31'h5A5A5A5A,   6'd0,  128'h0},
    '{1'b1, RADIX_W'(10), 31'h2AAAAAAA,   6'd0,  128'h0},
    '{1'b0, RADIX_W'(0),  31'h55555555,   6'd0,  128'h0}
  };

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [RADIX_W-1:0] cfg_wdata;

  rdc_value_if value_ch ();
  rdc_digit_if digit_ch ();

  radix_digit_converter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .value_ch  (value_ch),
    .digit_ch  (digit_ch)
  );

  // Digits still owed by the block, oldest first, across all values in flight.
  digit_item_t        pending_digits [$];
  digit_item_t        oldest_digit;
  // The testbench's own copy of the radix register.
  logic [RADIX_W-1:0] radix_shadow;
  int                 src_idle_pct;
  int                 sink_idle_pct;
  logic               long_stall_pending;
  int                 stall_left;
  int                 quiet_cycles;
  int                 error_count;

  initial begin
    clk = 1'b0;
  end

  always #CLK_HALF clk = ~clk;

  // Register values below two act as two and values above sixteen as sixteen.
  function automatic int unsigned effective_base(input logic [RADIX_W-1:0] reg_val);
    int unsigned base;
    if (reg_val < 2) begin
      base = 2;
    end else if (reg_val > 16) begin
      base = 16;
    end else begin
      base = 32'(reg_val);
    end
    return base;
  endfunction

  // Divides repeatedly until the quotient is zero, so the digit count is
  // exact and has no leading zeros; zero still gives one digit. The
  // remainders come out least significant first and are queued most
  // significant first, with the final flag on the last one queued.
  function automatic void predict_digits(input logic [VALUE_BITS-1:0] v,
                                         input logic [RADIX_W-1:0] reg_val);
    int unsigned        base;
    int unsigned        quotient;
    logic [DIGIT_W-1:0] remainders [$];
    digit_item_t        item;
    base     = effective_base(reg_val);
    quotient = 32'(v);
    do begin
      remainders.push_back(DIGIT_W'(quotient % base));
      quotient = quotient / base;
    end while (quotient != 0);
    for (int k = remainders.size() - 1; k >= 0; k--) begin
      item.digit      = remainders[k];
      item.last_digit = (k == 0);
      pending_digits.push_back(item);
    end
  endfunction

  // Random values: full width, small, a power of the radix or one below it
  // (the points where the digit count changes), or the top bit set.
  function automatic logic [VALUE_BITS-1:0] pick_value(input int unsigned base);
    longint unsigned       power;
    int unsigned           steps;
    logic [VALUE_BITS-1:0] v;
    case ($urandom_range(0, 3))
      0: begin
        v = VALUE_BITS'($urandom());
      end
      1: begin
        v = VALUE_BITS'($urandom_range(0, 300));
      end
      2: begin
        power = 1;
        steps = $urandom_range(1, VALUE_BITS);
        while (steps > 0 && power * base < (64'd1 << VALUE_BITS)) begin
          power = power * base;
          steps--;
        end
        v = VALUE_BITS'(($urandom_range(0, 1) == 1) ? power : power - 1);
      end
      default: begin
        v = {1'b1, UPPER_BITS'($urandom())};
      end
    endcase
    return v;
  endfunction

  // Offers one value, with random idle cycles in front of it, and waits for
  // the transaction. The expected digits are queued at the accepting edge.
  // Valid is left high, so back-to-back values need no gap.
  task automatic send_value(input logic [VALUE_BITS-1:0] v,
                            input logic [5:0]            typed_count,
                            input logic [127:0]          typed_digits);
    digit_item_t item;
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      value_ch.valid = 1'b0;
      value_ch.value = VALUE_BITS'($urandom());
      @(negedge clk);
    end
    value_ch.valid = 1'b1;
    value_ch.value = v;
    do begin
      @(posedge clk);
    end while (value_ch.ready !== 1'b1);
    if (typed_count == 0) begin
      predict_digits(v, radix_shadow);
    end else begin
      for (int k = 0; k < typed_count; k++) begin
        item.digit      = typed_digits[4 * (typed_count - 1 - k) +: 4];
        item.last_digit = (k == typed_count - 1);
        pending_digits.push_back(item);
      end
    end
  endtask

  // The radix may change only with no conversion in flight: stop offering,
  // let every owed digit drain, give the block a few cycles, then write.
  task automatic write_radix(input logic [RADIX_W-1:0] r);
    @(negedge clk);
    value_ch.valid = 1'b0;
    while (pending_digits.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = r;
    @(negedge clk);
    cfg_we       = 1'b0;
    cfg_wdata    = RADIX_W'($urandom());
    radix_shadow = r;
  endtask

  // Receiver side: ready changes at the falling edge. A long hold-off, once
  // requested, is counted down here while the sender keeps offering values,
  // so the output register fills and the block stops taking input.
  always @(negedge clk) begin
    if (long_stall_pending) begin
      stall_left         = LONG_STALL_CYCLES;
      long_stall_pending = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      digit_ch.ready = 1'b0;
    end else begin
      digit_ch.ready = ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Every digit transaction is checked against the oldest owed digit.
  always @(posedge clk) begin
    if (!rst && digit_ch.valid === 1'b1 && digit_ch.ready === 1'b1) begin
      if (pending_digits.size() == 0) begin
        $error("unexpected digit transaction: digit %0h last_digit %0b",
               digit_ch.digit, digit_ch.last_digit);
        error_count++;
      end else begin
        oldest_digit = pending_digits.pop_front();
        if (digit_ch.digit !== oldest_digit.digit) begin
          $error("digit mismatch: expected %0h, actual %0h",
                 oldest_digit.digit, digit_ch.digit);
          error_count++;
        end
        if (digit_ch.last_digit !== oldest_digit.last_digit) begin
          $error("last_digit mismatch: expected %0b, actual %0b",
                 oldest_digit.last_digit, digit_ch.last_digit);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a stretch with no transaction on either channel means a hang.
  always @(posedge clk) begin
    if ((value_ch.valid === 1'b1 && value_ch.ready === 1'b1) ||
        (digit_ch.valid === 1'b1 && digit_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("radix_digit_converter_tb failed");
        $finish;
      end
    end
  end

  initial begin
    directed_row_t row;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    value_ch.valid     = 1'b0;
    value_ch.value     = '0;
    digit_ch.ready     = 1'b0;
    radix_shadow       = RADIX_RESET;
    src_idle_pct       = 16;
    sink_idle_pct      = 78;
    long_stall_pending = 1'b0;
    stall_left         = 0;
    quiet_cycles       = 0;
    error_count        = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, walked row by row. Register writes happen only between
    // rows, once the block has drained.
    foreach (directed_table[i]) begin
      row = directed_table[i];
      if (row.set_radix) begin
        write_radix(row.radix);
      end
      send_value(row.value, row.typed_count, row.typed_digits);
    end

    // Random part in three idling phases: a slow receiver, then a slow
    // sender, then neither idles. Each phase walks several radix settings:
    // values that all act as two, values that all act as sixteen, and two
    // fully random register values.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 16;
          sink_idle_pct = 78;
        end
        1: begin
          src_idle_pct  = 78;
          sink_idle_pct = 16;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        case (seg)
          0:       write_radix(RADIX_W'($urandom_range(0, 2)));
          1:       write_radix(RADIX_W'($urandom_range(16, 31)));
          default: write_radix(RADIX_W'($urandom_range(0, 31)));
        endcase
        for (int n = 0; n < ITEMS_PER_SEGMENT; n++) begin
          // With neither side idling, one long receiver hold-off backs the
          // block up into its input channel.
          if (phase == PHASES - 1 && seg == 1 && n == 3) begin
            long_stall_pending = 1'b1;
          end
          send_value(pick_value(effective_base(radix_shadow)), 6'd0, 128'h0);
        end
      end
    end

    @(negedge clk);
    value_ch.valid = 1'b0;
    while (pending_digits.size() != 0) begin
      @(posedge clk);
    end
    // A few more cycles so that any stray extra digit is caught.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_digits.size() == 0) begin
      $display("radix_digit_converter_tb passed");
    end else begin
      $display("radix_digit_converter_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
